// ===== hw/rtl/rgbyuv_pkg.sv =====
package rgbyuv_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_HEIGHT  = 4096;
	localparam int LINE_DEPTH  = MAX_WIDTH / 2;
	localparam int LINE_AW     = $clog2(LINE_DEPTH);
	localparam int CNT_W       = $clog2(MAX_WIDTH);
	localparam int SIZE_W      = 13;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1920;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd1080;

	localparam logic [23:0] LUMA_R = 24'd13933;
	localparam logic [23:0] LUMA_G = 24'd46871;
	localparam logic [23:0] LUMA_B = 24'd4732;

	localparam logic signed [27:0] CU_R   = -28'sd7509;
	localparam logic signed [27:0] CU_G   = -28'sd25259;
	localparam logic signed [27:0] CU_B   = 28'sd32768;
	localparam logic signed [27:0] CV_R   = 28'sd32768;
	localparam logic signed [27:0] CV_G   = -28'sd29763;
	localparam logic signed [27:0] CV_B   = -28'sd3005;
	localparam logic signed [27:0] C_BIAS = 28'sd33554432;

	typedef struct packed {
		logic [8:0] sum_b;
		logic [8:0] sum_g;
		logic [8:0] sum_r;
	} pair_sum_t;

	typedef struct packed {
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		pair_sum_t          pair;
		logic [LINE_AW-1:0] line_idx;
		logic               line_wr;
		logic               chroma;
		logic               frame_end;
	} entry_t;

endpackage

// ===== hw/rtl/rgbyuv_stream_if.sv =====
interface rgbyuv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgbyuv_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma;
	logic       chroma_valid;
	logic [7:0] chroma_u;
	logic [7:0] chroma_v;
	logic       frame_end;

	modport source (output valid, luma, chroma_valid, chroma_u, chroma_v, frame_end,
		input ready);
	modport sink (input valid, luma, chroma_valid, chroma_u, chroma_v, frame_end,
		output ready);
endinterface

// ===== hw/rtl/rgbyuv_front.sv =====
module rgbyuv_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [0:0]                    cfg_index,
	input  logic [rgbyuv_pkg::SIZE_W-1:0] cfg_data,
	rgbyuv_in_if.sink                     pix_in,
	input  logic                          full,
	output logic                          push,
	output rgbyuv_pkg::entry_t            entry
);

	logic [rgbyuv_pkg::SIZE_W-1:0] width_q;
	logic [rgbyuv_pkg::SIZE_W-1:0] height_q;
	logic [rgbyuv_pkg::CNT_W-1:0]  col_q;
	logic [rgbyuv_pkg::CNT_W-1:0]  row_q;
	logic [23:0]                   left_q;
	logic [rgbyuv_pkg::SIZE_W-1:0] eff_w;
	logic [rgbyuv_pkg::SIZE_W-1:0] eff_h;
	logic                          last_col;
	logic                          last_row;

	function automatic logic [rgbyuv_pkg::SIZE_W-1:0] eff_size(
		input logic [rgbyuv_pkg::SIZE_W-1:0] raw,
		input logic [rgbyuv_pkg::SIZE_W-1:0] limit
	);
		logic [rgbyuv_pkg::SIZE_W-1:0] v;
		v = {raw[rgbyuv_pkg::SIZE_W-1:1], 1'b0};
		if (v < 13'd2) v = 13'd2;
		if (v > limit) v = limit;
		return v;
	endfunction

	assign eff_w    = eff_size(width_q, rgbyuv_pkg::SIZE_W'(rgbyuv_pkg::MAX_WIDTH));
	assign eff_h    = eff_size(height_q, rgbyuv_pkg::SIZE_W'(rgbyuv_pkg::MAX_HEIGHT));
	assign last_col = ({1'b0, col_q} + 13'd1) >= eff_w;
	assign last_row = ({1'b0, row_q} + 13'd1) >= eff_h;

	assign pix_in.ready = !full;
	assign push         = pix_in.valid && !full;

	always_comb begin
		entry.red          = pix_in.red;
		entry.green        = pix_in.green;
		entry.blue         = pix_in.blue;
		entry.pair.sum_r   = {1'b0, pix_in.red} + {1'b0, left_q[7:0]};
		entry.pair.sum_g   = {1'b0, pix_in.green} + {1'b0, left_q[15:8]};
		entry.pair.sum_b   = {1'b0, pix_in.blue} + {1'b0, left_q[23:16]};
		entry.line_idx     = col_q[rgbyuv_pkg::CNT_W-1:1];
		entry.line_wr      = col_q[0] && !row_q[0];
		entry.chroma       = col_q[0] && row_q[0];
		entry.frame_end    = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rgbyuv_pkg::WIDTH_RESET;
			height_q <= rgbyuv_pkg::HEIGHT_RESET;
		end else if (cfg_write) begin
			if (cfg_index == rgbyuv_pkg::REG_IMAGE_WIDTH) width_q <= cfg_data;
			else height_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (push) begin
			if (!col_q[0]) left_q <= {pix_in.blue, pix_in.green, pix_in.red};
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/rgbyuv_queue.sv =====
module rgbyuv_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rgbyuv_pkg::entry_t push_entry,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output rgbyuv_pkg::entry_t head
);

	rgbyuv_pkg::entry_t                 slot_q [rgbyuv_pkg::QUEUE_DEPTH];
	logic [rgbyuv_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [rgbyuv_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [rgbyuv_pkg::QUEUE_CW-1:0]   count_q;
	logic                              do_pop;

	assign full   = count_q == rgbyuv_pkg::QUEUE_CW'(rgbyuv_pkg::QUEUE_DEPTH);
	assign empty  = count_q == '0;
	assign head   = slot_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/rgbyuv_back.sv =====
module rgbyuv_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  rgbyuv_pkg::entry_t head,
	output logic               pop,
	rgbyuv_out_if.source       pix_out
);

	rgbyuv_pkg::pair_sum_t line_mem [rgbyuv_pkg::LINE_DEPTH];

	logic                  en;
	logic [23:0]           y_sum;

	logic                  v_s1;
	logic [7:0]            luma_s1;
	logic                  chroma_s1;
	logic                  fe_s1;
	rgbyuv_pkg::pair_sum_t pair_s1;
	rgbyuv_pkg::pair_sum_t rd_s1;

	logic                  v_s2;
	logic [7:0]            luma_s2;
	logic                  chroma_s2;
	logic                  fe_s2;
	logic [9:0]            sr_s2;
	logic [9:0]            sg_s2;
	logic [9:0]            sb_s2;

	logic                  out_valid_q;
	logic [7:0]            luma_q;
	logic                  chroma_q;
	logic [7:0]            u_q;
	logic [7:0]            v_q;
	logic                  fe_q;

	logic signed [27:0]    u_acc;
	logic signed [27:0]    v_acc;
	logic [7:0]            u_val;
	logic [7:0]            v_val;

	function automatic logic [7:0] clamp8(input logic signed [27:0] acc);
		logic [7:0] q;
		if (acc[27]) q = 8'd0;
		else if (acc[26:18] > 9'd255) q = 8'd255;
		else q = acc[25:18];
		return q;
	endfunction

	assign en  = !out_valid_q || pix_out.ready;
	assign pop = en && !empty;

	assign y_sum = rgbyuv_pkg::LUMA_R * {16'd0, head.red}
		+ rgbyuv_pkg::LUMA_G * {16'd0, head.green}
		+ rgbyuv_pkg::LUMA_B * {16'd0, head.blue};

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.line_wr) line_mem[head.line_idx] <= head.pair;
			rd_s1 <= line_mem[head.line_idx];
		end
	end

	always_comb begin
		u_acc = rgbyuv_pkg::CU_R * $signed({18'd0, sr_s2})
			+ rgbyuv_pkg::CU_G * $signed({18'd0, sg_s2})
			+ rgbyuv_pkg::CU_B * $signed({18'd0, sb_s2})
			+ rgbyuv_pkg::C_BIAS;
		v_acc = rgbyuv_pkg::CV_R * $signed({18'd0, sr_s2})
			+ rgbyuv_pkg::CV_G * $signed({18'd0, sg_s2})
			+ rgbyuv_pkg::CV_B * $signed({18'd0, sb_s2})
			+ rgbyuv_pkg::C_BIAS;
		u_val = chroma_s2 ? clamp8(u_acc) : 8'd0;
		v_val = chroma_s2 ? clamp8(v_acc) : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= !empty;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!empty) begin
				luma_s1   <= y_sum[23:16];
				chroma_s1 <= head.chroma;
				fe_s1     <= head.frame_end;
				pair_s1   <= head.pair;
			end
			luma_s2   <= luma_s1;
			chroma_s2 <= chroma_s1;
			fe_s2     <= fe_s1;
			sr_s2     <= {1'b0, pair_s1.sum_r} + {1'b0, rd_s1.sum_r};
			sg_s2     <= {1'b0, pair_s1.sum_g} + {1'b0, rd_s1.sum_g};
			sb_s2     <= {1'b0, pair_s1.sum_b} + {1'b0, rd_s1.sum_b};
			luma_q    <= luma_s2;
			chroma_q  <= chroma_s2;
			fe_q      <= fe_s2;
			u_q       <= u_val;
			v_q       <= v_val;
		end
	end

	assign pix_out.valid        = out_valid_q;
	assign pix_out.luma         = luma_q;
	assign pix_out.chroma_valid = chroma_q;
	assign pix_out.chroma_u     = u_q;
	assign pix_out.chroma_v     = v_q;
	assign pix_out.frame_end    = fe_q;

endmodule

// ===== hw/rtl/rgb_to_yuv420_stream_top.sv =====
// RGB to YUV 4:2:0 (BT.709) stream converter.
// pix_in takes one RGB pixel per transfer in raster order; pix_out gives one
// result per pixel: luma always, U and V with chroma_valid on the odd column
// of an odd row, frame_end on the last pixel of the frame.
// image_width and image_height are set through cfg_write/cfg_index/cfg_data
// while the stream is idle; odd sizes round down, sizes clamp to 2..4096.
// Throughput: one pixel per cycle while pix_out is ready; the line store is
// accessed at one address per pixel.
// A result passes through the queue, the line store read, the chroma sum and
// the output register before it is valid on pix_out.
// Reset clears the counters, the left-pixel hold, the queue and all valids;
// the line store keeps no reset value and is filled by each even row.
// When pix_out stalls, the back pipeline holds and the 4-entry queue fills;
// pix_in.ready drops only once the queue is full.
module rgb_to_yuv420_stream_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [0:0]                    cfg_index,
	input  logic [rgbyuv_pkg::SIZE_W-1:0] cfg_data,
	rgbyuv_in_if.sink                     pix_in,
	rgbyuv_out_if.source                  pix_out
);

	rgbyuv_pkg::entry_t push_entry;
	rgbyuv_pkg::entry_t head;
	logic               push;
	logic               pop;
	logic               full;
	logic               empty;

	rgbyuv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_in),
		.full      (full),
		.push      (push),
		.entry     (push_entry)
	);

	rgbyuv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.empty      (empty),
		.head       (head)
	);

	rgbyuv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.pix_out (pix_out)
	);

endmodule

// ===== tb/rgb_to_yuv420_stream_top_tb.sv =====
`timescale 1ns / 100ps

module rgb_to_yuv420_stream_top_tb;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PRESSURE_AT = 300;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASES      = 12;
	localparam int SEED_COUNT  = 24;
	localparam int RESET_PIXELS = 4;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
		logic       frame_end;
	} yuv_result_t;

	class yuv420_scoreboard;
		localparam int unsigned LUMA_KR = 13933;
		localparam int unsigned LUMA_KG = 46871;
		localparam int unsigned LUMA_KB = 4732;
		localparam longint U_KR = -7509;
		localparam longint U_KG = -25259;
		localparam longint U_KB = 32768;
		localparam longint V_KR = 32768;
		localparam longint V_KG = -29763;
		localparam longint V_KB = -3005;
		localparam longint CHROMA_BIAS = longint'(128) << 18;
		localparam int LINE_SLOTS = 2048;
		localparam int MAX_PRINTS = 100;

		logic [12:0]   width_reg;
		logic [12:0]   height_reg;
		int unsigned   col;
		int unsigned   row;
		logic [7:0]    left_r;
		logic [7:0]    left_g;
		logic [7:0]    left_b;
		logic [8:0]    line_r [LINE_SLOTS];
		logic [8:0]    line_g [LINE_SLOTS];
		logic [8:0]    line_b [LINE_SLOTS];
		yuv_result_t   pending [$];
		int            errors;

		function new();
			width_reg = 13'd1920;
			height_reg = 13'd1080;
			col = 0;
			row = 0;
			left_r = '0;
			left_g = '0;
			left_b = '0;
			errors = 0;
		endfunction

		function void write_reg(rgbyuv_pkg::reg_index_t idx, logic [12:0] val);
			case (idx)
				rgbyuv_pkg::REG_IMAGE_WIDTH: width_reg = val;
				rgbyuv_pkg::REG_IMAGE_HEIGHT: height_reg = val;
				default: ;
			endcase
		endfunction

		function int unsigned frame_size(logic [12:0] val);
			int unsigned v;
			v = 32'(val & 13'h1FFE);
			if (v < 2) v = 2;
			if (v > 4096) v = 4096;
			return v;
		endfunction

		function int unsigned chroma_of(longint kr, longint kg, longint kb,
				longint sr, longint sg, longint sb);
			longint acc;
			acc = kr * sr + kg * sg + kb * sb + CHROMA_BIAS;
			if (acc < 0) return 0;
			acc = acc >>> 18;
			return (acc > 255) ? 255 : 32'(acc);
		endfunction

		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int unsigned w;
			int unsigned h;
			int unsigned luma;
			int unsigned idx;
			logic [8:0]  pr;
			logic [8:0]  pg;
			logic [8:0]  pb;
			longint      sr;
			longint      sg;
			longint      sb;
			bit          last_col;
			bit          last_row;
			yuv_result_t res;
			w = frame_size(width_reg);
			h = frame_size(height_reg);
			res = '0;
			luma = (LUMA_KR * r + LUMA_KG * g + LUMA_KB * b) >> 16;
			res.luma = 8'(luma);
			last_col = (col + 1 >= w);
			last_row = (row + 1 >= h);
			if (col % 2 == 0) begin
				left_r = r;
				left_g = g;
				left_b = b;
			end else begin
				pr = {1'b0, r} + left_r;
				pg = {1'b0, g} + left_g;
				pb = {1'b0, b} + left_b;
				idx = (col / 2) % LINE_SLOTS;
				if (row % 2 == 0) begin
					line_r[idx] = pr;
					line_g[idx] = pg;
					line_b[idx] = pb;
				end else begin
					sr = longint'(pr) + longint'(line_r[idx]);
					sg = longint'(pg) + longint'(line_g[idx]);
					sb = longint'(pb) + longint'(line_b[idx]);
					res.chroma_u = 8'(chroma_of(U_KR, U_KG, U_KB, sr, sg, sb));
					res.chroma_v = 8'(chroma_of(V_KR, V_KG, V_KB, sr, sg, sb));
					res.chroma_valid = 1'b1;
				end
			end
			res.frame_end = last_col && last_row;
			pending.push_back(res);
			if (last_col) begin
				col = 0;
				row = last_row ? 0 : ((row + 1) & 32'hFFF);
			end else begin
				col = (col + 1) & 32'h3FFF;
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTS) $display("mismatch: %s", msg);
		endtask

		task check_result(yuv_result_t got);
			yuv_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("result with nothing expected, luma %0d", got.luma));
				return;
			end
			want = pending.pop_front();
			if (got.luma !== want.luma)
				report($sformatf("luma got %0d expected %0d", got.luma, want.luma));
			if (got.chroma_valid !== want.chroma_valid)
				report($sformatf("chroma_valid got %0b expected %0b",
					got.chroma_valid, want.chroma_valid));
			if (got.chroma_u !== want.chroma_u)
				report($sformatf("chroma_u got %0d expected %0d",
					got.chroma_u, want.chroma_u));
			if (got.chroma_v !== want.chroma_v)
				report($sformatf("chroma_v got %0d expected %0d",
					got.chroma_v, want.chroma_v));
			if (got.frame_end !== want.frame_end)
				report($sformatf("frame_end got %0b expected %0b",
					got.frame_end, want.frame_end));
		endtask
	endclass

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          cfg_write;
	logic [0:0]                    cfg_index;
	logic [rgbyuv_pkg::SIZE_W-1:0] cfg_data;

	rgbyuv_in_if  pix_in ();
	rgbyuv_out_if pix_out ();

	rgb_to_yuv420_stream_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_in),
		.pix_out   (pix_out)
	);

	yuv420_scoreboard sb;
	int results_seen = 0;
	int quiet_left [2] = '{0, 0};

	logic [23:0] seed_pixels [SEED_COUNT] = '{
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h0000FF,
		24'h000000, 24'h0000FF, 24'h0000FF,
		24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF,
		24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000,
		24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00,
		24'h808080, 24'hFFFFFF, 24'h000000, 24'h7F7F7F,
		24'hFFFFFF
	};

	logic [12:0] phase_w [PHASES] = '{
		13'd4, 13'd6, 13'd1, 13'd0, 13'd8191, 13'd16,
		13'd4097, 13'd10, 13'd12, 13'd2, 13'd7, 13'd4096
	};
	logic [12:0] phase_h [PHASES] = '{
		13'd2, 13'd4, 13'd3, 13'd0, 13'd8191, 13'd6,
		13'd5, 13'd4096, 13'd2, 13'd4, 13'd4095, 13'd2
	};
	int phase_n [PHASES] = '{60, 96, 40, 30, 70, 140, 50, 120, 100, 80, 90, 60};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap(input int side);
		int roll;
		if (quiet_left[side] > 0) begin
			quiet_left[side]--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			quiet_left[side] = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [23:0] random_pixel();
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		r = 8'($urandom);
		g = 8'($urandom);
		b = 8'($urandom);
		case ($urandom_range(0, 9))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return {r, r, r};
			default: return {r, g, b};
		endcase
	endfunction

	// call at a falling edge; returns at the falling edge after the transfer
	task automatic push_pixel(input logic [23:0] rgb);
		int gap;
		gap = pick_gap(0);
		if (gap > 0) begin
			pix_in.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.valid = 1'b1;
		{pix_in.red, pix_in.green, pix_in.blue} = rgb;
		do @(posedge clk); while (!pix_in.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input rgbyuv_pkg::reg_index_t idx, input logic [12:0] val);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic program_size(input logic [12:0] w, input logic [12:0] h);
		write_reg(rgbyuv_pkg::REG_IMAGE_WIDTH, w);
		write_reg(rgbyuv_pkg::REG_IMAGE_HEIGHT, h);
		cfg_write = 1'b0;
	endtask

	// pad to an even row so a width change never reads an unwritten line entry
	task automatic close_phase();
		while (sb.row % 2 != 0) push_pixel(random_pixel());
		pix_in.valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	initial begin
		sb = new();
		cfg_write = 1'b0;
		cfg_index = rgbyuv_pkg::REG_IMAGE_WIDTH;
		cfg_data = '0;
		pix_in.valid = 1'b0;
		pix_in.red = '0;
		pix_in.green = '0;
		pix_in.blue = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < RESET_PIXELS; i++) push_pixel(seed_pixels[i]);
		close_phase();
		program_size(13'd2, 13'd2);
		for (int i = RESET_PIXELS; i < SEED_COUNT; i++) push_pixel(seed_pixels[i]);
		close_phase();

		for (int p = 0; p < PHASES; p++) begin
			program_size(phase_w[p], phase_h[p]);
			repeat (phase_n[p]) push_pixel(random_pixel());
			close_phase();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		int stall_left;
		bit pressure_done;
		stall_left = 0;
		pressure_done = 1'b0;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!pressure_done && results_seen >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				pix_out.ready = 1'b0;
				stall_left--;
			end else begin
				pix_out.ready = 1'b1;
				stall_left = pick_gap(1);
			end
		end
	end

	initial begin
		yuv_result_t got;
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			idle_cycles++;
			if (pix_in.valid && pix_in.ready) begin
				sb.note_pixel(pix_in.red, pix_in.green, pix_in.blue);
				idle_cycles = 0;
			end
			if (pix_out.valid && pix_out.ready) begin
				got.luma = pix_out.luma;
				got.chroma_valid = pix_out.chroma_valid;
				got.chroma_u = pix_out.chroma_u;
				got.chroma_v = pix_out.chroma_v;
				got.frame_end = pix_out.frame_end;
				sb.check_result(got);
				results_seen++;
				idle_cycles = 0;
			end
		end
		$display("status: fail");
		$finish;
	end

endmodule
